### src/mepf_pkg.sv
// Types and constants shared by the envelope/peak follower modules.
// No dependencies.
`timescale 1ns / 1ps

package mepf_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int LEVEL_BITS    = SAMPLE_BITS - 1;
    localparam int COEFF_BITS    = 16;
    localparam int MULB_BITS     = COEFF_BITS + 1;
    localparam int ACC_BITS      = LEVEL_BITS + MULB_BITS;
    localparam int HOLD_BITS     = 16;
    localparam int BAND_BITS     = 3;
    localparam int BANDS         = 8;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 16;
    localparam int IN_DATA_BITS  = 24;
    localparam int OUT_DATA_BITS = 72;

    typedef logic [LEVEL_BITS-1:0]    t_level;
    typedef logic [COEFF_BITS-1:0]    t_coeff;
    typedef logic [MULB_BITS-1:0]     t_mulb;
    typedef logic [ACC_BITS-1:0]      t_acc;
    typedef logic [HOLD_BITS-1:0]     t_hold;
    typedef logic [BAND_BITS-1:0]     t_band;
    typedef logic [CFG_IDX_BITS-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_BITS-1:0] t_cfg_data;

    localparam t_mulb  COEFF_ONE   = t_mulb'(1) << COEFF_BITS;
    localparam t_acc   ROUND_HALF  = t_acc'(1) << (COEFF_BITS - 1);
    localparam t_level MAG_MAX     = {LEVEL_BITS{1'b1}};
    localparam int     SMOOTH_KEEP_I = ((19 << COEFF_BITS) + 10) / 20;
    localparam t_mulb  SMOOTH_KEEP = t_mulb'(SMOOTH_KEEP_I);
    localparam t_mulb  SMOOTH_TAKE = COEFF_ONE - SMOOTH_KEEP;

    localparam t_cfg_idx CFG_ATTACK  = 4'd0;
    localparam t_cfg_idx CFG_RELEASE = 4'd1;
    localparam t_cfg_idx CFG_HOLD    = 4'd2;
    localparam t_cfg_idx CFG_DECAY   = 4'd3;

    localparam t_coeff RST_ATTACK  = 16'd65000;
    localparam t_coeff RST_RELEASE = 16'd65500;
    localparam t_hold  RST_HOLD    = 16'd0;
    localparam t_coeff RST_DECAY   = 16'd65533;

    typedef struct packed {
        t_level env;
        t_level smooth;
        t_level peak;
        t_hold  hold;
    } t_state_rec;

    typedef struct packed {
        logic       en;
        t_band      band;
        t_state_rec rec;
    } t_state_wr;

    typedef struct packed {
        logic load;
        logic accum;
        logic round;
    } t_mac_ctrl;

endpackage

### src/mepf_mac.sv
// Shared multiply-accumulate unit with a registered accumulator.
// Depends on mepf_pkg.
`timescale 1ns / 1ps

module mepf_mac (
    input  logic               i_clk,
    input  mepf_pkg::t_mac_ctrl i_ctrl,
    input  mepf_pkg::t_level   i_a,
    input  mepf_pkg::t_mulb    i_b,
    output mepf_pkg::t_acc     o_acc
);

    mepf_pkg::t_acc r_acc;
    mepf_pkg::t_acc n_acc;
    mepf_pkg::t_acc w_prod;

    assign w_prod = mepf_pkg::t_acc'(i_a) * mepf_pkg::t_acc'(i_b);

    always_comb begin
        n_acc = (i_ctrl.accum ? r_acc : '0) + w_prod
              + (i_ctrl.round ? mepf_pkg::ROUND_HALF : '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

### src/mepf_state.sv
// Per-band follower state: envelope, smoothed level, peak and hold count.
// Depends on mepf_pkg.
`timescale 1ns / 1ps

module mepf_state (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mepf_pkg::t_band       i_rd_band,
    output mepf_pkg::t_state_rec  o_rd_rec,
    input  mepf_pkg::t_state_wr   i_wr
);

    mepf_pkg::t_state_rec r_mem [mepf_pkg::BANDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mepf_pkg::BANDS; i++) begin
                r_mem[i] <= '0;
            end
        end else if (i_wr.en) begin
            r_mem[i_wr.band] <= i_wr.rec;
        end
    end

    assign o_rd_rec = r_mem[i_rd_band];

endmodule

### src/multiband_envelope_peak_follower_core.sv
// Top level of the multiband envelope follower with peak hold.
// Depends on mepf_pkg, mepf_mac, mepf_state.
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser band, tdata sample
// m_axis    out  m_axis_tvalid / m_axis_tready  tuser band, tdata levels
// cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// A request steps through accept, five passes through the shared
// multiply-accumulate unit (attack/release filter, smoothing, peak decay),
// then write-back. s_axis_tready is high only in the idle state.
// Write-back waits while the output register holds an untaken result.
// Reset is synchronous and clears all band state; config is always ready.
`timescale 1ns / 1ps

module multiband_envelope_peak_follower_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [23:0] sample
    input  logic [2:0]  s_axis_tuser,   // [2:0] band
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [22:0] envelope_out, [45:23] smoothed_out,
                                        // [68:46] peak_out, [71:69] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] band_out
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENV_A,
        ST_ENV_B,
        ST_SM_A,
        ST_SM_B,
        ST_PEAK,
        ST_WB
    } t_state;

    t_state                r_state;
    mepf_pkg::t_coeff      r_attack;
    mepf_pkg::t_coeff      r_release;
    mepf_pkg::t_hold       r_hold_len;
    mepf_pkg::t_coeff      r_decay;

    mepf_pkg::t_band       r_band;
    mepf_pkg::t_level      r_mag;
    mepf_pkg::t_state_rec  r_cur;
    mepf_pkg::t_level      r_env;
    mepf_pkg::t_level      r_smooth;

    logic                  r_out_valid;
    mepf_pkg::t_band       r_out_band;
    mepf_pkg::t_level      r_out_env;
    mepf_pkg::t_level      r_out_smooth;
    mepf_pkg::t_level      r_out_peak;

    logic [mepf_pkg::SAMPLE_BITS-1:0] w_abs;
    mepf_pkg::t_level      n_mag;
    mepf_pkg::t_state_rec  w_rd_rec;
    mepf_pkg::t_state_wr   w_wr;
    mepf_pkg::t_mac_ctrl   w_mac_ctrl;
    mepf_pkg::t_level      w_mac_a;
    mepf_pkg::t_mulb       w_mac_b;
    mepf_pkg::t_acc        w_acc;
    mepf_pkg::t_level      w_acc_hi;
    mepf_pkg::t_mulb       w_pole;
    logic                  w_out_free;

    // magnitude, most negative sample saturates
    always_comb begin
        w_abs = s_axis_tdata[mepf_pkg::SAMPLE_BITS-1]
              ? (~s_axis_tdata + mepf_pkg::SAMPLE_BITS'(1)) : s_axis_tdata;
        n_mag = w_abs[mepf_pkg::SAMPLE_BITS-1]
              ? mepf_pkg::MAG_MAX : w_abs[mepf_pkg::LEVEL_BITS-1:0];
    end

    assign w_pole   = (r_mag > r_cur.env) ? {1'b0, r_attack} : {1'b0, r_release};
    assign w_acc_hi = w_acc[mepf_pkg::COEFF_BITS +: mepf_pkg::LEVEL_BITS];

    always_comb begin
        w_mac_ctrl = '0;
        w_mac_a    = '0;
        w_mac_b    = '0;
        case (r_state)
            ST_ENV_A: begin
                w_mac_ctrl = '{load: 1'b1, accum: 1'b0, round: 1'b0};
                w_mac_a    = r_cur.env;
                w_mac_b    = w_pole;
            end
            ST_ENV_B: begin
                w_mac_ctrl = '{load: 1'b1, accum: 1'b1, round: 1'b1};
                w_mac_a    = r_mag;
                w_mac_b    = mepf_pkg::COEFF_ONE - w_pole;
            end
            ST_SM_A: begin
                w_mac_ctrl = '{load: 1'b1, accum: 1'b0, round: 1'b0};
                w_mac_a    = r_cur.smooth;
                w_mac_b    = mepf_pkg::SMOOTH_KEEP;
            end
            ST_SM_B: begin
                w_mac_ctrl = '{load: 1'b1, accum: 1'b1, round: 1'b1};
                w_mac_a    = r_env;
                w_mac_b    = mepf_pkg::SMOOTH_TAKE;
            end
            ST_PEAK: begin
                w_mac_ctrl = '{load: 1'b1, accum: 1'b0, round: 1'b0};
                w_mac_a    = r_cur.peak;
                w_mac_b    = {1'b0, r_decay};
            end
            default: begin
                w_mac_ctrl = '0;
            end
        endcase
    end

    assign w_out_free = !r_out_valid || m_axis_tready;

    // write-back record; accumulator holds the decayed peak here
    always_comb begin
        w_wr.en         = (r_state == ST_WB) && w_out_free;
        w_wr.band       = r_band;
        w_wr.rec.env    = r_env;
        w_wr.rec.smooth = r_smooth;
        if (r_mag >= r_cur.peak) begin
            w_wr.rec.peak = r_mag;
            w_wr.rec.hold = r_hold_len;
        end else if (r_cur.hold != '0) begin
            w_wr.rec.peak = r_cur.peak;
            w_wr.rec.hold = r_cur.hold - mepf_pkg::HOLD_BITS'(1);
        end else begin
            w_wr.rec.peak = w_acc_hi;
            w_wr.rec.hold = r_cur.hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_attack    <= mepf_pkg::RST_ATTACK;
            r_release   <= mepf_pkg::RST_RELEASE;
            r_hold_len  <= mepf_pkg::RST_HOLD;
            r_decay     <= mepf_pkg::RST_DECAY;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    mepf_pkg::CFG_ATTACK:  r_attack   <= i_cfg_data;
                    mepf_pkg::CFG_RELEASE: r_release  <= i_cfg_data;
                    mepf_pkg::CFG_HOLD:    r_hold_len <= i_cfg_data;
                    mepf_pkg::CFG_DECAY:   r_decay    <= i_cfg_data;
                    default: ;
                endcase
            end
            // write-back refills the output register itself
            if (r_out_valid && m_axis_tready && (r_state != ST_WB)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_band  <= s_axis_tuser;
                        r_mag   <= n_mag;
                        r_cur   <= w_rd_rec;
                        r_state <= ST_ENV_A;
                    end
                end
                ST_ENV_A: r_state <= ST_ENV_B;
                ST_ENV_B: r_state <= ST_SM_A;
                ST_SM_A: begin
                    r_env   <= w_acc_hi;
                    r_state <= ST_SM_B;
                end
                ST_SM_B: r_state <= ST_PEAK;
                ST_PEAK: begin
                    r_smooth <= w_acc_hi;
                    r_state  <= ST_WB;
                end
                ST_WB: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_band   <= r_band;
                        r_out_env    <= w_wr.rec.env;
                        r_out_smooth <= w_wr.rec.smooth;
                        r_out_peak   <= w_wr.rec.peak;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    mepf_state u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_band (s_axis_tuser),
        .o_rd_rec  (w_rd_rec),
        .i_wr      (w_wr)
    );

    mepf_mac u_mac (
        .i_clk  (i_clk),
        .i_ctrl (w_mac_ctrl),
        .i_a    (w_mac_a),
        .i_b    (w_mac_b),
        .o_acc  (w_acc)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_band;
    assign m_axis_tdata  = {3'b000, r_out_peak, r_out_smooth, r_out_env};

endmodule

### src/mepf_checker.sv
// Port-level checks for the envelope/peak follower core, bound to the top.
// Depends on multiband_envelope_peak_follower_core.
`timescale 1ns / 1ps

module mepf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic        o_cfg_ready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a request");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[71:69] == 3'b000 && o_cfg_ready)
        else $error("output padding nonzero or config not ready");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("not idle after reset");

endmodule

bind multiband_envelope_peak_follower_core mepf_checker u_mepf_checker (.*);

### bench/testbench.sv
// Self-checking bench for multiband_envelope_peak_follower_core: a band/sample stream
// is checked against an in-bench follower predictor. Depends on mepf_pkg and the core.
`timescale 1ns / 1ps

module testbench;

    localparam int     CYCLE_LIMIT   = 400000;
    localparam int     PHASE_ITEMS   = 130;
    localparam int     HOLDOFF_LEN   = 400;
    localparam longint SMOOTH_POLE   = ((64'd19 << mepf_pkg::COEFF_BITS) + 64'd10) / 64'd20;
    localparam int     DIR_ROWS_N    = 21;
    localparam int     HOLD_ROWS_AT  = 16;

    typedef struct packed {
        mepf_pkg::t_band  band;
        mepf_pkg::t_level env;
        mepf_pkg::t_level smooth;
        mepf_pkg::t_level peak;
    } t_levels;

    typedef struct packed {
        mepf_pkg::t_band band;
        logic [23:0]     sample;
        logic            typed;
        t_levels         want;
    } t_stim_row;

    localparam t_levels ZERO_LV = '0;

    // typed rows: zero input right after reset leaves every level at zero
    localparam t_stim_row DIR_ROWS [DIR_ROWS_N] = '{
        '{3'd0, 24'h000000, 1'b1, '{3'd0, 23'd0, 23'd0, 23'd0}},
        '{3'd7, 24'h000000, 1'b1, '{3'd7, 23'd0, 23'd0, 23'd0}},
        '{3'd1, 24'h7FFFFF, 1'b0, ZERO_LV},
        '{3'd1, 24'h800000, 1'b0, ZERO_LV},
        '{3'd1, 24'hFFFFFF, 1'b0, ZERO_LV},
        '{3'd1, 24'h000000, 1'b0, ZERO_LV},
        '{3'd1, 24'h000000, 1'b0, ZERO_LV},
        '{3'd2, 24'h800001, 1'b0, ZERO_LV},
        '{3'd2, 24'h000001, 1'b0, ZERO_LV},
        '{3'd2, 24'h000001, 1'b0, ZERO_LV},
        '{3'd3, 24'h400000, 1'b0, ZERO_LV},
        '{3'd3, 24'hC00000, 1'b0, ZERO_LV},
        '{3'd4, 24'h555555, 1'b0, ZERO_LV},
        '{3'd5, 24'hAAAAAA, 1'b0, ZERO_LV},
        '{3'd6, 24'h000064, 1'b0, ZERO_LV},
        '{3'd6, 24'hFFFF9C, 1'b0, ZERO_LV},
        // hold length 2: reload, two held samples, then decay
        '{3'd0, 24'h100000, 1'b0, ZERO_LV},
        '{3'd0, 24'h000000, 1'b0, ZERO_LV},
        '{3'd0, 24'h000000, 1'b0, ZERO_LV},
        '{3'd0, 24'h000000, 1'b0, ZERO_LV},
        '{3'd0, 24'h000000, 1'b0, ZERO_LV}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    multiband_envelope_peak_follower_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // follower state and register shadow
    mepf_pkg::t_level env_st    [mepf_pkg::BANDS];
    mepf_pkg::t_level smooth_st [mepf_pkg::BANDS];
    mepf_pkg::t_level peak_st   [mepf_pkg::BANDS];
    mepf_pkg::t_hold  hold_st   [mepf_pkg::BANDS];
    mepf_pkg::t_coeff attack_c;
    mepf_pkg::t_coeff release_c;
    mepf_pkg::t_hold  hold_len;
    mepf_pkg::t_coeff decay_c;

    t_levels pending_levels [$];
    int      fail_count;
    int      cycle_count;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      holdoff_req;
    int      holdoff_ack;
    int      holdoff_left;
    t_levels seen_lv;
    t_levels due_lv;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic mepf_pkg::t_level pole_step(longint unsigned keep,
                                                   longint unsigned prev,
                                                   longint unsigned mag);
        longint unsigned acc;
        acc = keep * prev + ((64'd1 << mepf_pkg::COEFF_BITS) - keep) * mag
            + (64'd1 << (mepf_pkg::COEFF_BITS - 1));
        acc = acc >> mepf_pkg::COEFF_BITS;
        return (acc > mepf_pkg::MAG_MAX) ? mepf_pkg::MAG_MAX : mepf_pkg::t_level'(acc);
    endfunction

    function automatic t_levels follow_band(mepf_pkg::t_band b, logic [23:0] s);
        longint unsigned mag;
        longint unsigned p;
        t_levels         r;
        mag = s[23] ? (64'd1 << 24) - 64'(s) : 64'(s);
        if (mag > mepf_pkg::MAG_MAX) mag = mepf_pkg::MAG_MAX;
        env_st[b] = pole_step((mag > env_st[b]) ? attack_c : release_c, env_st[b], mag);
        smooth_st[b] = pole_step(SMOOTH_POLE, smooth_st[b], env_st[b]);
        if (mag >= peak_st[b]) begin
            peak_st[b] = mepf_pkg::t_level'(mag);
            hold_st[b] = hold_len;
        end else if (hold_st[b] != '0) begin
            hold_st[b] = hold_st[b] - 1'b1;
        end else begin
            p = (64'(peak_st[b]) * 64'(decay_c)) >> mepf_pkg::COEFF_BITS;
            peak_st[b] = mepf_pkg::t_level'(p);
        end
        r.band   = b;
        r.env    = env_st[b];
        r.smooth = smooth_st[b];
        r.peak   = peak_st[b];
        return r;
    endfunction

    task automatic send_sample(mepf_pkg::t_band b, logic [23:0] s, logic typed,
                               t_levels want);
        t_levels pred;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= b;
        s_axis_tdata  <= s;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = follow_band(b, s);
        pending_levels.push_back(typed ? want : pred);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic cfg_write(mepf_pkg::t_cfg_idx idx, mepf_pkg::t_cfg_data val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            mepf_pkg::CFG_ATTACK:  attack_c  = val;
            mepf_pkg::CFG_RELEASE: release_c = val;
            mepf_pkg::CFG_HOLD:    hold_len  = val;
            mepf_pkg::CFG_DECAY:   decay_c   = val;
            default: ;
        endcase
    endtask

    task automatic apply_setting(mepf_pkg::t_coeff a, mepf_pkg::t_coeff r,
                                 mepf_pkg::t_hold h, mepf_pkg::t_coeff d);
        cfg_write(mepf_pkg::CFG_ATTACK, a);
        cfg_write(mepf_pkg::CFG_RELEASE, r);
        cfg_write(mepf_pkg::CFG_HOLD, h);
        cfg_write(mepf_pkg::CFG_DECAY, d);
        // unmapped index, must be ignored
        cfg_write(mepf_pkg::t_cfg_idx'($urandom_range(int'(mepf_pkg::CFG_DECAY) + 1,
                                                      (1 << mepf_pkg::CFG_IDX_BITS) - 1)),
                  mepf_pkg::t_cfg_data'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // result side: random stalls plus a long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        holdoff_ack   = 0;
        holdoff_left  = 0;
        forever begin
            @(posedge i_clk);
            if (holdoff_left > 0) begin
                holdoff_left = holdoff_left - 1;
                m_axis_tready <= 1'b0;
            end else if (holdoff_req != holdoff_ack) begin
                holdoff_ack  = holdoff_req;
                holdoff_left = HOLDOFF_LEN;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_lv = '{m_axis_tuser, m_axis_tdata[22:0], m_axis_tdata[45:23],
                        m_axis_tdata[68:46]};
            if (pending_levels.size() == 0) begin
                $error("unexpected result: band_out %0d", seen_lv.band);
                fail_count++;
            end else begin
                due_lv = pending_levels.pop_front();
                if (seen_lv.band != due_lv.band) begin
                    $error("band_out: expected %0d, got %0d", due_lv.band, seen_lv.band);
                    fail_count++;
                end
                if (seen_lv.env != due_lv.env) begin
                    $error("envelope_out: expected %0d, got %0d", due_lv.env, seen_lv.env);
                    fail_count++;
                end
                if (seen_lv.smooth != due_lv.smooth) begin
                    $error("smoothed_out: expected %0d, got %0d",
                           due_lv.smooth, seen_lv.smooth);
                    fail_count++;
                end
                if (seen_lv.peak != due_lv.peak) begin
                    $error("peak_out: expected %0d, got %0d", due_lv.peak, seen_lv.peak);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[multiband_envelope_peak_follower_core] ERROR");
            $finish;
        end
    end

    initial begin
        mepf_pkg::t_band b;
        logic [23:0]     s;
        logic [23:0]     last_sample [mepf_pkg::BANDS];
        int              sel;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        fail_count     = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_req    = 0;
        attack_c       = mepf_pkg::RST_ATTACK;
        release_c      = mepf_pkg::RST_RELEASE;
        hold_len       = mepf_pkg::RST_HOLD;
        decay_c        = mepf_pkg::RST_DECAY;
        b              = '0;
        for (int k = 0; k < mepf_pkg::BANDS; k++) begin
            env_st[k]      = '0;
            smooth_st[k]   = '0;
            peak_st[k]     = '0;
            hold_st[k]     = '0;
            last_sample[k] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS_N; i++) begin
            if (i == HOLD_ROWS_AT) begin
                drain_results();
                apply_setting(mepf_pkg::RST_ATTACK, mepf_pkg::RST_RELEASE, 16'd2,
                              mepf_pkg::RST_DECAY);
            end
            send_sample(DIR_ROWS[i].band, DIR_ROWS[i].sample, DIR_ROWS[i].typed,
                        DIR_ROWS[i].want);
        end
        drain_results();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    apply_setting(16'd0, 16'hFFFF, 16'd3, 16'd0);
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    holdoff_req    = holdoff_req + 1;
                end
                1: begin
                    apply_setting(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
                    send_idle_pct  = 85;
                    recv_stall_pct = 0;
                end
                2: begin
                    apply_setting(mepf_pkg::t_coeff'($urandom), mepf_pkg::t_coeff'($urandom),
                                  mepf_pkg::t_hold'($urandom_range(0, 12)),
                                  mepf_pkg::t_coeff'($urandom));
                    send_idle_pct  = 0;
                    recv_stall_pct = 85;
                end
                3: begin
                    apply_setting(mepf_pkg::t_coeff'($urandom), mepf_pkg::t_coeff'($urandom),
                                  mepf_pkg::t_hold'($urandom_range(0, 5)),
                                  mepf_pkg::t_coeff'($urandom));
                    send_idle_pct  = 29;
                    recv_stall_pct = 29;
                end
                default: begin
                    apply_setting(16'd60000, 16'd65500, 16'd7, 16'd62000);
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 3) != 0) begin
                    b = mepf_pkg::t_band'($urandom_range(0, mepf_pkg::BANDS - 1));
                end
                sel = $urandom_range(0, 15);
                case (sel)
                    0:       s = 24'h800000;
                    1:       s = 24'h7FFFFF;
                    2:       s = '0;
                    3:       s = last_sample[b];
                    4:       s = -last_sample[b];
                    5, 6:    s = 24'(int'($urandom_range(0, 511)) - 256);
                    7, 8:    s = $signed(last_sample[b]) >>> 1;
                    default: s = 24'($urandom);
                endcase
                send_sample(b, s, 1'b0, ZERO_LV);
                last_sample[b] = s;
            end
            drain_results();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending_levels.size() == 0) begin
            $display("[multiband_envelope_peak_follower_core] OK");
        end else begin
            $display("[multiband_envelope_peak_follower_core] ERROR");
        end
        $finish;
    end

endmodule
